// ===== sv/id3tfe_pkg.sv =====
// Shared types, constants and UTF-8 helpers for the ID3v2 text frame extractor.
// Used by every module of the block; depends on nothing.
`default_nettype none
package id3tfe_pkg;

  localparam int TEXT_SIZE_DEF     = 256;
  localparam int MAX_TAG_BYTES_DEF = 262144;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [31:0] ID_TIT2 = 32'h54495432;
  localparam logic [31:0] ID_TPE1 = 32'h54504531;
  localparam logic [31:0] ID_TALB = 32'h54414c42;

  localparam logic [1:0] FIELD_TITLE  = 2'd0;
  localparam logic [1:0] FIELD_ARTIST = 2'd1;
  localparam logic [1:0] FIELD_ALBUM  = 2'd2;

  localparam logic [7:0] ENC_LATIN1   = 8'd0;
  localparam logic [7:0] ENC_UTF16    = 8'd1;
  localparam logic [7:0] ENC_UTF16_BE = 8'd2;
  localparam logic [7:0] ENC_UTF8     = 8'd3;

  localparam logic [0:0] KIND_CLEAR  = 1'b0;
  localparam logic [0:0] KIND_APPEND = 1'b1;

  localparam logic [0:0] REG_TAG_LENGTH  = 1'b0;
  localparam logic [0:0] REG_TAG_VERSION = 1'b1;

  // Work for the back end: a clear, or up to two characters of one field.
  typedef struct packed {
    logic        clr;
    logic [1:0]  field;
    logic        a_v;
    logic        a_raw;
    logic [20:0] a_cp;
    logic        b_v;
    logic [20:0] b_cp;
  } job_t;

  function automatic logic [2:0] utf8_count(input logic [20:0] cp);
    logic [2:0] n;
    if (cp <= 21'h7f) n = 3'd1;
    else if (cp <= 21'h7ff) n = 3'd2;
    else if (cp <= 21'hffff) n = 3'd3;
    else n = 3'd4;
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] n,
                                           input logic [1:0] idx);
    logic [7:0] r;
    r = 8'h80 | {2'b00, cp[5:0]};
    case (n)
      3'd1: r = cp[7:0];
      3'd2: if (idx == 2'd0) r = 8'hc0 | {3'b000, cp[10:6]};
      3'd3: begin
        if (idx == 2'd0) r = 8'he0 | {4'b0000, cp[15:12]};
        else if (idx == 2'd1) r = 8'h80 | {2'b00, cp[11:6]};
      end
      default: begin
        if (idx == 2'd0) r = 8'hf0 | {5'b00000, cp[20:18]};
        else if (idx == 2'd1) r = 8'h80 | {2'b00, cp[17:12]};
        else if (idx == 2'd2) r = 8'h80 | {2'b00, cp[11:6]};
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/id3tfe_if.sv =====
// Valid/ready channel interfaces for tag bytes in and text items out.
// Stand-alone; used by the top level.
`default_nettype none
interface id3tfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] tag_byte;
  modport source (output valid, output tag_byte, input ready);
  modport sink (input valid, input tag_byte, output ready);
endinterface

interface id3tfe_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] field_select;
  logic       item_kind;
  logic [7:0] text_byte;
  logic       last_of_run;
  modport source (output valid, output field_select, output item_kind, output text_byte,
                  output last_of_run, input ready);
  modport sink (input valid, input field_select, input item_kind, input text_byte,
                input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== sv/id3tfe_front.sv =====
// Front end: frame header parsing, encoding handling, UTF-16 unit assembly
// and per-field length limiting. Emits jobs for the back end; uses id3tfe_pkg.
`default_nettype none
module id3tfe_front #(
  parameter int TEXT_SIZE     = id3tfe_pkg::TEXT_SIZE_DEF,
  parameter int MAX_TAG_BYTES = id3tfe_pkg::MAX_TAG_BYTES_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 accept,
  input  wire  [7:0]          tag_byte,
  input  wire  [18:0]         tag_length,
  input  wire  [2:0]          tag_version,
  output logic                push,
  output id3tfe_pkg::job_t    job
);

  localparam int LW = (TEXT_SIZE > 2) ? $clog2(TEXT_SIZE) : 1;
  localparam int SW = LW + 3;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_ENC    = 6'b000010,
    PH_SINGLE = 6'b000100,
    PH_UTF16  = 6'b001000,
    PH_SKIP   = 6'b010000,
    PH_HALT   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  first_byte;
    logic        first_unit;
    logic        msb_first;
    logic        has_high;
    logic [15:0] high;
  } unit_t;

  phase_t        phase, phase_next;
  logic [63:0]   hdr, hdr_next;
  logic [3:0]    hcnt, hcnt_next;
  logic [18:0]   consumed, consumed_next;
  logic [18:0]   remaining, remaining_next;
  logic [1:0]    field, field_next;
  logic          latin, latin_next;
  unit_t         unit, unit_next;
  logic [LW-1:0] lens [3];
  logic [LW-1:0] lens_next [3];

  always_comb begin
    logic [18:0] limit, c1, avail, rem_dec;
    logic        start_bad;
    logic [31:0] raw, size32;
    logic        hit;
    logic [1:0]  fsel;
    logic [15:0] u;
    logic        a_v, a_raw, b_v, ok_a, ok_b;
    logic [20:0] a_cp, b_cp;
    logic [2:0]  cnt_a, cnt_b;
    logic [SW-1:0] cur, len_a, len_b;

    phase_next     = phase;
    hdr_next       = hdr;
    hcnt_next      = hcnt;
    consumed_next  = consumed;
    remaining_next = remaining;
    field_next     = field;
    latin_next     = latin;
    unit_next      = unit;
    lens_next      = lens;
    a_v = 1'b0; a_raw = 1'b0; a_cp = '0; b_v = 1'b0; b_cp = '0;
    u = '0;

    limit     = (tag_length > 19'(MAX_TAG_BYTES)) ? '0 : tag_length;
    start_bad = ({1'b0, consumed} + 20'd10) > {1'b0, limit};
    c1        = consumed + 19'd1;
    avail     = (limit > c1) ? limit - c1 : '0;
    rem_dec   = (remaining != '0) ? remaining - 19'd1 : remaining;
    raw       = hdr[31:0];
    size32    = (tag_version == 3'd4) ?
                {4'b0, raw[30:24], raw[22:16], raw[14:8], raw[6:0]} : raw;
    hit  = 1'b1;
    fsel = id3tfe_pkg::FIELD_TITLE;
    if (hdr[63:32] == id3tfe_pkg::ID_TIT2) fsel = id3tfe_pkg::FIELD_TITLE;
    else if (hdr[63:32] == id3tfe_pkg::ID_TPE1) fsel = id3tfe_pkg::FIELD_ARTIST;
    else if (hdr[63:32] == id3tfe_pkg::ID_TALB) fsel = id3tfe_pkg::FIELD_ALBUM;
    else hit = 1'b0;

    job     = '0;
    job.clr = 1'b0;

    if (accept) begin
      if (phase == PH_HEADER) begin
        if (hcnt == 4'd0 && (start_bad || tag_byte == 8'd0)) begin
          phase_next = PH_HALT;
        end else begin
          consumed_next = c1;
          if (hcnt < 4'd8) hdr_next = {hdr[55:0], tag_byte};
          if (hcnt == 4'd9) begin
            hcnt_next = '0;
            if (size32 == '0 || size32 > {13'b0, avail}) begin
              phase_next = PH_HALT;
            end else begin
              remaining_next = size32[18:0];
              unit_next      = '0;
              if (hit && size32 > 32'd1) begin
                field_next      = fsel;
                lens_next[fsel] = '0;
                phase_next      = PH_ENC;
                job.clr         = 1'b1;
              end else begin
                phase_next = PH_SKIP;
              end
            end
          end else begin
            hcnt_next = hcnt + 4'd1;
          end
        end
      end else if (phase != PH_HALT) begin
        consumed_next  = c1;
        remaining_next = rem_dec;
        if (phase == PH_ENC) begin
          latin_next = (tag_byte == id3tfe_pkg::ENC_LATIN1);
          if (tag_byte == id3tfe_pkg::ENC_LATIN1 || tag_byte == id3tfe_pkg::ENC_UTF8) begin
            phase_next = PH_SINGLE;
          end else if (tag_byte == id3tfe_pkg::ENC_UTF16 ||
                       tag_byte == id3tfe_pkg::ENC_UTF16_BE) begin
            phase_next           = PH_UTF16;
            unit_next.first_unit = 1'b1;
            unit_next.msb_first  = (tag_byte == id3tfe_pkg::ENC_UTF16_BE);
          end else begin
            phase_next = PH_SKIP;
          end
        end else if (phase == PH_SINGLE) begin
          if (tag_byte == 8'd0) phase_next = PH_SKIP;
          else begin
            a_v   = 1'b1;
            a_raw = !latin;
            a_cp  = {13'b0, tag_byte};
          end
        end else if (phase == PH_UTF16) begin
          if (!unit.has_byte) begin
            unit_next.has_byte   = 1'b1;
            unit_next.first_byte = tag_byte;
          end else begin
            unit_next.has_byte = 1'b0;
            if (unit.first_unit && unit.first_byte == 8'hff && tag_byte == 8'hfe) begin
              unit_next.first_unit = 1'b0;
              unit_next.msb_first  = 1'b0;
            end else if (unit.first_unit && unit.first_byte == 8'hfe &&
                         tag_byte == 8'hff) begin
              unit_next.first_unit = 1'b0;
              unit_next.msb_first  = 1'b1;
            end else begin
              unit_next.first_unit = 1'b0;
              u = unit.msb_first ? {unit.first_byte, tag_byte} : {tag_byte, unit.first_byte};
              unit_next.has_high = 1'b0;
              if (unit.has_high && u >= 16'hdc00 && u <= 16'hdfff) begin
                // Surrogate pair joins into one supplementary character.
                a_v  = 1'b1;
                a_cp = 21'h10000 + {1'b0, unit.high[9:0], u[9:0]};
              end else begin
                if (unit.has_high) begin
                  a_v  = 1'b1;
                  a_cp = {5'b0, unit.high};
                end
                if (u == 16'd0) begin
                  phase_next = PH_SKIP;
                end else if (u >= 16'hd800 && u <= 16'hdbff && rem_dec >= 19'd2) begin
                  unit_next.has_high = 1'b1;
                  unit_next.high     = u;
                end else begin
                  b_v  = 1'b1;
                  b_cp = {5'b0, u};
                end
              end
            end
          end
        end
        if (rem_dec == '0) begin
          phase_next = PH_HEADER;
          unit_next  = '0;
        end
      end
    end

    // Length limit, applied in emission order.
    cnt_a = a_raw ? 3'd1 : id3tfe_pkg::utf8_count(a_cp);
    cnt_b = id3tfe_pkg::utf8_count(b_cp);
    cur   = SW'(lens[field]);
    ok_a  = a_v && ((cur + SW'(cnt_a)) < SW'(TEXT_SIZE));
    len_a = ok_a ? cur + SW'(cnt_a) : cur;
    ok_b  = b_v && ((len_a + SW'(cnt_b)) < SW'(TEXT_SIZE));
    len_b = ok_b ? len_a + SW'(cnt_b) : len_a;
    if (ok_a || ok_b) lens_next[field] = len_b[LW-1:0];

    job.field = job.clr ? field_next : field;
    job.a_v   = ok_a;
    job.a_raw = a_raw;
    job.a_cp  = a_cp;
    job.b_v   = ok_b;
    job.b_cp  = b_cp;
    push      = job.clr || ok_a || ok_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      hdr       <= '0;
      hcnt      <= '0;
      consumed  <= '0;
      remaining <= '0;
      field     <= '0;
      latin     <= 1'b1;
      unit      <= '0;
      lens      <= '{default: '0};
    end else begin
      phase     <= phase_next;
      hdr       <= hdr_next;
      hcnt      <= hcnt_next;
      consumed  <= consumed_next;
      remaining <= remaining_next;
      field     <= field_next;
      latin     <= latin_next;
      unit      <= unit_next;
      lens      <= lens_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/id3tfe_queue.sv =====
// Short job queue between the front and back ends.
// Uses id3tfe_pkg for the job type.
`default_nettype none
module id3tfe_queue #(
  parameter int DEPTH = id3tfe_pkg::QUEUE_DEPTH
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  input  id3tfe_pkg::job_t        push_job,
  input  wire                     pop,
  output id3tfe_pkg::job_t        head,
  output logic                    empty,
  output logic                    full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  id3tfe_pkg::job_t slots [DEPTH];
  logic [PW-1:0] wptr, rptr;

  assign empty = (count == '0);
  assign full  = (count == ($clog2(DEPTH+1))'(DEPTH));
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      if (pop && !empty) rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      count <= count + ($clog2(DEPTH+1))'(push && !full) - ($clog2(DEPTH+1))'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

// ===== sv/id3tfe_back.sv =====
// Back end: expands one job into clear and UTF-8 byte items, one per cycle while ready is high.
// Uses id3tfe_pkg for the job type and the UTF-8 helpers.
`default_nettype none
module id3tfe_back (
  input  wire                 clk,
  input  wire                 rst,
  input  id3tfe_pkg::job_t    head,
  input  wire                 empty,
  output logic                pop,
  output logic                valid,
  input  wire                 ready,
  output logic [1:0]          field_select,
  output logic                item_kind,
  output logic [7:0]          text_byte,
  output logic                last_of_run
);

  typedef enum logic [2:0] {
    PART_CLR = 3'b001,
    PART_A   = 3'b010,
    PART_B   = 3'b100
  } part_t;

  id3tfe_pkg::job_t job;
  part_t            part;
  logic [1:0]       idx;
  logic             job_valid;

  logic [20:0] cp;
  logic        raw;
  logic [2:0]  cnt;
  logic        part_last, has_next, advance, done;

  always_comb begin
    cp  = (part == PART_B) ? job.b_cp : job.a_cp;
    raw = (part == PART_A) && job.a_raw;
    cnt = (part == PART_CLR || raw) ? 3'd1 : id3tfe_pkg::utf8_count(cp);
    unique case (part)
      PART_CLR: has_next = job.a_v || job.b_v;
      PART_A:   has_next = job.b_v;
      PART_B:   has_next = 1'b0;
      default:  has_next = 1'b0;
    endcase
    if (part == PART_CLR) text_byte = 8'd0;
    else if (raw) text_byte = cp[7:0];
    else text_byte = id3tfe_pkg::utf8_byte(cp, cnt, idx);
  end

  assign part_last    = (idx == 2'(cnt - 3'd1));
  assign valid        = 1'b1 & job_valid;
  assign field_select = job.field;
  assign item_kind    = (part == PART_CLR) ? id3tfe_pkg::KIND_CLEAR : id3tfe_pkg::KIND_APPEND;
  assign last_of_run  = part_last && !has_next;
  assign advance      = valid && ready;
  assign done         = advance && last_of_run;
  assign pop          = !empty && (!job_valid || done);

  always_ff @(posedge clk) begin
    if (pop) job <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      part      <= PART_CLR;
      idx       <= '0;
    end else if (pop) begin
      job_valid <= 1'b1;
      idx       <= '0;
      part      <= head.clr ? PART_CLR : (head.a_v ? PART_A : PART_B);
    end else if (done) begin
      job_valid <= 1'b0;
    end else if (advance) begin
      if (part_last) begin
        idx  <= '0;
        part <= (part == PART_CLR && job.a_v) ? PART_A : PART_B;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/id3v2_text_frame_extractor.sv =====
// Top level of the ID3v2 text frame extractor: configuration registers,
// front end, job queue and back end. Uses id3tfe_pkg, id3tfe_if and submodules.
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    tag_byte
//  out_ch    out  valid/ready    field_select, item_kind, text_byte, last_of_run
//  cfg       in   cfg_we         cfg_index, cfg_wdata
//
// A tag byte is taken in every cycle in which the job queue has room; the
// front end handles it in that cycle and queues at most one job.
// The back end sends one output item a cycle while out_ch is ready; an input byte
// causes up to six output items, so the output port sets the rate.
// Reset is synchronous and clears all control state and the field lengths.
// Either side may stall at any time; the four-entry queue decouples them.
`default_nettype none
module id3v2_text_frame_extractor #(
  parameter int TEXT_SIZE     = id3tfe_pkg::TEXT_SIZE_DEF,
  parameter int MAX_TAG_BYTES = id3tfe_pkg::MAX_TAG_BYTES_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire  [0:0]          cfg_index,
  input  wire  [18:0]         cfg_wdata,
  id3tfe_in_if.sink           in_ch,
  id3tfe_out_if.source        out_ch
);

  localparam int QD = id3tfe_pkg::QUEUE_DEPTH;

  logic [18:0] tag_length;
  logic [2:0]  tag_version;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_length  <= '0;
      tag_version <= 3'd3;
    end else if (cfg_we) begin
      if (cfg_index == id3tfe_pkg::REG_TAG_LENGTH) tag_length <= cfg_wdata;
      else tag_version <= cfg_wdata[2:0];
    end
  end

  id3tfe_pkg::job_t        fjob, head;
  logic                    push, pop, empty, full;
  logic [$clog2(QD+1)-1:0] count;

  assign in_ch.ready = !full;

  id3tfe_front #(.TEXT_SIZE(TEXT_SIZE), .MAX_TAG_BYTES(MAX_TAG_BYTES)) u_front (
    .clk(clk), .rst(rst), .accept(in_ch.valid && in_ch.ready), .tag_byte(in_ch.tag_byte),
    .tag_length(tag_length), .tag_version(tag_version), .push(push), .job(fjob)
  );

  id3tfe_queue #(.DEPTH(QD)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_job(fjob), .pop(pop), .head(head),
    .empty(empty), .full(full), .count(count)
  );

  id3tfe_back u_back (
    .clk(clk), .rst(rst), .head(head), .empty(empty), .pop(pop),
    .valid(out_ch.valid), .ready(out_ch.ready), .field_select(out_ch.field_select),
    .item_kind(out_ch.item_kind), .text_byte(out_ch.text_byte),
    .last_of_run(out_ch.last_of_run)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ($clog2(QD+1))'(QD)) else $error("job queue count exceeds depth");
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.item_kind == id3tfe_pkg::KIND_CLEAR |->
      out_ch.text_byte == 8'd0 && out_ch.last_of_run) else $error("bad clear item");
  a_pop_fills: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_ch.valid) else $error("popped job not presented");
`endif

endmodule
`default_nettype wire

// ===== test/tb_id3v2_text_frame_extractor.sv =====
// Self-checking testbench for the ID3v2 text frame extractor.
// Depends on id3tfe_pkg, id3tfe_if and the top level; predicts the text items
// from generated tag bodies and compares them in order.
`timescale 1ns / 100ps

module tb_id3v2_text_frame_extractor;

  localparam int TEXT_LIMIT  = id3tfe_pkg::TEXT_SIZE_DEF;
  localparam int TAG_MAX     = id3tfe_pkg::MAX_TAG_BYTES_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 30;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [5:0] {
    P_HEADER   = 6'b000001,
    P_ENCODING = 6'b000010,
    P_SINGLE   = 6'b000100,
    P_UTF16    = 6'b001000,
    P_SKIP     = 6'b010000,
    P_HALT     = 6'b100000
  } parse_phase_t;

  typedef struct packed {
    logic [1:0] field;
    logic       kind;
    logic [7:0] data;
    logic       last;
  } text_item_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [18:0] cfg_wdata;

  id3tfe_in_if  in_if();
  id3tfe_out_if out_if();

  id3v2_text_frame_extractor DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_ch(in_if), .out_ch(out_if)
  );

  always #4 clk = ~clk;

  // Stimulus and expected text items.
  logic [7:0] tag_bytes_q[$];
  logic [7:0] frame_body[$];
  text_item_t expected_text[$];
  text_item_t run_items[$];

  int errors = 0;
  int bytes_sent = 0;
  int items_checked = 0;
  int stall_cycles = 0;
  int hold_cnt = 0;
  bit held = 1'b0;
  bit steady = 1'b0;
  bit in_taken = 1'b0;

  // Mirror of the block's configuration and state.
  logic [18:0]  cfg_len;
  logic [2:0]   cfg_ver;
  parse_phase_t phase;
  logic [63:0]  hdr_bits;
  int           hdr_cnt;
  int           consumed;
  int           frame_left;
  logic [1:0]   cur_field;
  logic [7:0]   enc_code;
  bit           pend_valid, first_unit, big_end, hi_valid;
  logic [7:0]   pend_byte;
  logic [15:0]  hi_unit;
  int           fld_len[3];

  task automatic add_item(input logic kind, input logic [7:0] data);
    run_items.push_back('{cur_field, kind, data, 1'b0});
  endtask

  task automatic clear_units();
    pend_valid = 0; first_unit = 0; big_end = 0; hi_valid = 0;
    pend_byte = '0; hi_unit = '0;
  endtask

  task automatic put_codepoint(input logic [20:0] cp);
    int n;
    n = (cp <= 21'h7f) ? 1 : (cp <= 21'h7ff) ? 2 : (cp <= 21'hffff) ? 3 : 4;
    if (fld_len[cur_field] + n >= TEXT_LIMIT) return;
    case (n)
      1: add_item(id3tfe_pkg::KIND_APPEND, cp[7:0]);
      2: begin
        add_item(id3tfe_pkg::KIND_APPEND, 8'hc0 | {3'b000, cp[10:6]});
        add_item(id3tfe_pkg::KIND_APPEND, 8'h80 | {2'b00, cp[5:0]});
      end
      3: begin
        add_item(id3tfe_pkg::KIND_APPEND, 8'he0 | {4'b0000, cp[15:12]});
        add_item(id3tfe_pkg::KIND_APPEND, 8'h80 | {2'b00, cp[11:6]});
        add_item(id3tfe_pkg::KIND_APPEND, 8'h80 | {2'b00, cp[5:0]});
      end
      default: begin
        add_item(id3tfe_pkg::KIND_APPEND, 8'hf0 | {5'b00000, cp[20:18]});
        add_item(id3tfe_pkg::KIND_APPEND, 8'h80 | {2'b00, cp[17:12]});
        add_item(id3tfe_pkg::KIND_APPEND, 8'h80 | {2'b00, cp[11:6]});
        add_item(id3tfe_pkg::KIND_APPEND, 8'h80 | {2'b00, cp[5:0]});
      end
    endcase
    fld_len[cur_field] += n;
  endtask

  task automatic take_unit(input logic [15:0] u);
    logic [20:0] cp;
    if (hi_valid) begin
      hi_valid = 0;
      if (u >= 16'hdc00 && u <= 16'hdfff) begin
        cp = 21'h10000 + ((21'(hi_unit) - 21'hd800) << 10) + (21'(u) - 21'hdc00);
        put_codepoint(cp);
        return;
      end
      put_codepoint(21'(hi_unit));
    end
    if (u == 16'h0) begin
      phase = P_SKIP;
      return;
    end
    // A high surrogate waits for its partner only if a full unit can follow.
    if (u >= 16'hd800 && u <= 16'hdbff && frame_left >= 2) begin
      hi_valid = 1;
      hi_unit = u;
      return;
    end
    put_codepoint(21'(u));
  endtask

  task automatic take_utf16_byte(input logic [7:0] b);
    logic [7:0] b0;
    if (!pend_valid) begin
      pend_valid = 1;
      pend_byte = b;
      return;
    end
    pend_valid = 0;
    b0 = pend_byte;
    if (first_unit) begin
      first_unit = 0;
      if (b0 == 8'hff && b == 8'hfe) begin big_end = 0; return; end
      if (b0 == 8'hfe && b == 8'hff) begin big_end = 1; return; end
    end
    take_unit(big_end ? {b0, b} : {b, b0});
  endtask

  task automatic predict_byte(input logic [7:0] b);
    logic [31:0] frame_id, raw, size;
    int limit, avail, f;
    run_items.delete();
    limit = (cfg_len > TAG_MAX) ? 0 : int'(cfg_len);
    if (phase == P_HALT) return;
    if (phase == P_HEADER) begin
      if (hdr_cnt == 0 && (consumed + 10 > limit || b == 8'h0)) begin
        phase = P_HALT;
        return;
      end
      consumed++;
      if (hdr_cnt < 8) hdr_bits = {hdr_bits[55:0], b};
      hdr_cnt++;
      if (hdr_cnt < 10) return;
      hdr_cnt = 0;
      frame_id = hdr_bits[63:32];
      raw = hdr_bits[31:0];
      if (cfg_ver == 3'd4) size = {4'h0, raw[30:24], raw[22:16], raw[14:8], raw[6:0]};
      else size = raw;
      avail = (limit > consumed) ? limit - consumed : 0;
      if (size == 0 || size > avail) begin
        phase = P_HALT;
        return;
      end
      frame_left = size;
      f = (frame_id == id3tfe_pkg::ID_TIT2) ? 0 : (frame_id == id3tfe_pkg::ID_TPE1) ? 1 :
          (frame_id == id3tfe_pkg::ID_TALB) ? 2 : -1;
      clear_units();
      if (f >= 0 && size > 1) begin
        cur_field = f[1:0];
        fld_len[f] = 0;
        phase = P_ENCODING;
        add_item(id3tfe_pkg::KIND_CLEAR, 8'h0);
      end else begin
        phase = P_SKIP;
      end
    end else begin
      consumed++;
      if (frame_left > 0) frame_left--;
      case (phase)
        P_ENCODING: begin
          enc_code = b;
          if (b == id3tfe_pkg::ENC_LATIN1 || b == id3tfe_pkg::ENC_UTF8) phase = P_SINGLE;
          else if (b == id3tfe_pkg::ENC_UTF16 || b == id3tfe_pkg::ENC_UTF16_BE) begin
            phase = P_UTF16;
            first_unit = 1;
            big_end = (b == id3tfe_pkg::ENC_UTF16_BE);
          end else phase = P_SKIP;
        end
        P_SINGLE: begin
          if (b == 8'h0) phase = P_SKIP;
          else if (enc_code == id3tfe_pkg::ENC_LATIN1) put_codepoint(21'(b));
          else if (fld_len[cur_field] + 1 < TEXT_LIMIT) begin
            add_item(id3tfe_pkg::KIND_APPEND, b);
            fld_len[cur_field] += 1;
          end
        end
        P_UTF16: take_utf16_byte(b);
        default: ;
      endcase
      if (frame_left == 0) begin
        phase = P_HEADER;
        clear_units();
      end
    end
    if (run_items.size() > 0) run_items[run_items.size() - 1].last = 1'b1;
    foreach (run_items[i]) expected_text.push_back(run_items[i]);
  endtask

  // Frame generation.
  task automatic push_unit(input logic [15:0] u, input bit be);
    if (be) begin frame_body.push_back(u[15:8]); frame_body.push_back(u[7:0]); end
    else begin frame_body.push_back(u[7:0]); frame_body.push_back(u[15:8]); end
  endtask

  task automatic emit_frame(input logic [31:0] frame_id);
    int size;
    logic [7:0] sb;
    size = frame_body.size();
    for (int k = 3; k >= 0; k--) tag_bytes_q.push_back(frame_id[8*k +: 8]);
    for (int k = 3; k >= 0; k--) begin
      if (cfg_ver == 3'd4) sb = 8'((size >> (7*k)) & 'h7f) | 8'($urandom_range(0, 1) << 7);
      else sb = 8'(size >> (8*k));
      tag_bytes_q.push_back(sb);
    end
    tag_bytes_q.push_back(8'($urandom));
    tag_bytes_q.push_back(8'($urandom));
    foreach (frame_body[i]) tag_bytes_q.push_back(frame_body[i]);
  endtask

  task automatic gen_frame();
    logic [31:0] frame_id;
    logic [7:0]  enc;
    logic [15:0] u;
    int sel, n;
    bit be;
    frame_body.delete();
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      frame_id = (sel % 3 == 0) ? id3tfe_pkg::ID_TIT2 :
                 (sel % 3 == 1) ? id3tfe_pkg::ID_TPE1 : id3tfe_pkg::ID_TALB;
      case ($urandom_range(0, 9))
        0, 1: enc = id3tfe_pkg::ENC_LATIN1;
        2, 3: enc = id3tfe_pkg::ENC_UTF8;
        4, 5, 6: enc = id3tfe_pkg::ENC_UTF16;
        7, 8: enc = id3tfe_pkg::ENC_UTF16_BE;
        default: enc = 8'($urandom_range(4, 255));
      endcase
      frame_body.push_back(enc);
      if ($urandom_range(0, 11) != 0) begin
        if (enc == id3tfe_pkg::ENC_LATIN1 || enc == id3tfe_pkg::ENC_UTF8) begin
          n = $urandom_range(1, 10);
          repeat (n)
            frame_body.push_back(($urandom_range(0, 9) == 0) ? 8'h0 : 8'($urandom_range(1, 255)));
        end else if (enc == id3tfe_pkg::ENC_UTF16 || enc == id3tfe_pkg::ENC_UTF16_BE) begin
          be = (enc == id3tfe_pkg::ENC_UTF16_BE);
          if ($urandom_range(0, 2) == 0) begin
            be = 1'($urandom_range(0, 1));
            push_unit(16'hfeff, be);
          end
          n = $urandom_range(1, 6);
          repeat (n) begin
            case ($urandom_range(0, 9))
              0, 1, 2: push_unit(16'($urandom_range(1, 'h7f)), be);
              3, 4: push_unit(16'($urandom), be);
              5, 6: begin
                push_unit(16'($urandom_range('hd800, 'hdbff)), be);
                push_unit(16'($urandom_range('hdc00, 'hdfff)), be);
              end
              7: push_unit(16'($urandom_range('hd800, 'hdbff)), be);
              8: push_unit(16'($urandom_range('hdc00, 'hdfff)), be);
              default: push_unit(16'h0, be);
            endcase
          end
          if ($urandom_range(0, 3) == 0) frame_body.push_back(8'($urandom));
        end else begin
          repeat ($urandom_range(1, 4)) frame_body.push_back(8'($urandom));
        end
      end
    end else begin
      frame_id = {8'($urandom_range(1, 255)), 24'($urandom)};
      repeat ($urandom_range(1, 8)) frame_body.push_back(8'($urandom));
    end
    emit_frame(frame_id);
  endtask

  task automatic gen_frames(input int nbytes);
    int start;
    start = tag_bytes_q.size();
    while (tag_bytes_q.size() - start < nbytes) gen_frame();
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [18:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == id3tfe_pkg::REG_TAG_LENGTH) cfg_len = val;
    else cfg_ver = val[2:0];
  endtask

  // Waits until every item is sent and every result is in, then lets the
  // block finish any byte that causes no result.
  task automatic wait_idle();
    wait (tag_bytes_q.size() == 0 && !in_if.valid && expected_text.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input text_item_t got, input text_item_t exp);
    errors++;
    $display("MISMATCH %s: got field %0d kind %0d byte %02h last %0d, want %0d %0d %02h %0d",
             what, got.field, got.kind, got.data, got.last,
             exp.field, exp.kind, exp.data, exp.last);
  endtask

  // Driver: holds an item until it is taken, then offers the next one.
  always @(negedge clk) begin
    if (!rst && !(in_if.valid && !in_taken)) begin
      if (tag_bytes_q.size() > 0 && (steady || $urandom_range(0, 99) >= 38)) begin
        in_if.valid <= 1'b1;
        in_if.tag_byte <= tag_bytes_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off once the stream is busy.
  always @(negedge clk) begin
    if (rst) out_if.ready <= 1'b0;
    else if (!held && bytes_sent >= 100) begin
      held <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= steady || ($urandom_range(0, 99) >= 38);
    end
  end

  // Monitor: predicts on every accepted byte and checks every text item.
  always @(posedge clk) begin
    text_item_t got, exp;
    if (!rst) begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        predict_byte(in_if.tag_byte);
        bytes_sent++;
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.field_select, out_if.item_kind, out_if.text_byte, out_if.last_of_run};
        items_checked++;
        if (expected_text.size() == 0) begin
          report_mismatch("unexpected item", got, '0);
        end else begin
          exp = expected_text.pop_front();
          if (got != exp) report_mismatch("item", got, exp);
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cycles <= 0;
      else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("Timeout: no item accepted for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.tag_byte = '0;
    out_if.ready = 1'b0;
    cfg_len = '0;
    cfg_ver = 3'd3;
    phase = P_HEADER;
    hdr_bits = '0;
    hdr_cnt = 0;
    consumed = 0;
    frame_left = 0;
    cur_field = '0;
    enc_code = '0;
    clear_units();
    foreach (fld_len[i]) fld_len[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: a Latin-1 title with the extremes of the byte range and a NUL
    // that ends the text early, then an artist frame with no text at all.
    write_reg(id3tfe_pkg::REG_TAG_LENGTH, 19'(TAG_MAX));
    write_reg(id3tfe_pkg::REG_TAG_VERSION, 19'd3);
    frame_body = '{id3tfe_pkg::ENC_LATIN1, 8'h01, 8'hff, 8'h7f, 8'h00, 8'h41};
    emit_frame(id3tfe_pkg::ID_TIT2);
    frame_body = '{id3tfe_pkg::ENC_UTF8};
    emit_frame(id3tfe_pkg::ID_TPE1);
    wait_idle();

    // Out-of-range lengths are only written while no byte is in flight.
    write_reg(id3tfe_pkg::REG_TAG_LENGTH, 19'd0);
    write_reg(id3tfe_pkg::REG_TAG_LENGTH, 19'h7ffff);
    write_reg(id3tfe_pkg::REG_TAG_LENGTH, 19'(TAG_MAX));
    write_reg(id3tfe_pkg::REG_TAG_VERSION, 19'd4);
    steady = 1'b1;
    gen_frames(25);
    wait_idle();
    steady = 1'b0;

    write_reg(id3tfe_pkg::REG_TAG_VERSION, 19'd3);
    gen_frames(25);
    wait_idle();

    write_reg(id3tfe_pkg::REG_TAG_VERSION, 19'd7);
    gen_frames(15);
    wait_idle();

    // A long album title runs into the field length limit: the last wide
    // character is dropped, and a short one after it still fits.
    write_reg(id3tfe_pkg::REG_TAG_VERSION, 19'd4);
    frame_body.delete();
    frame_body.push_back(id3tfe_pkg::ENC_LATIN1);
    repeat (128) frame_body.push_back(8'($urandom_range('h80, 'hff)));
    frame_body.push_back(8'h41);
    frame_body.push_back(8'h42);
    emit_frame(id3tfe_pkg::ID_TALB);
    gen_frames(10);
    wait_idle();

    // A frame larger than the bytes left halts the block; later bytes are ignored.
    write_reg(id3tfe_pkg::REG_TAG_LENGTH, 19'(consumed + 12));
    frame_body = '{id3tfe_pkg::ENC_LATIN1, 8'h41, 8'h42, 8'h43, 8'h44};
    emit_frame(id3tfe_pkg::ID_TIT2);
    repeat (8) tag_bytes_q.push_back(8'($urandom));
    wait_idle();

    $display("Sent %0d tag bytes and checked %0d text items across versions 3, 4 and 7,",
             bytes_sent, items_checked);
    $display("including a long hold-off, the length limit and a final halt.");
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/id3tfe_pkg.sv
sv/id3tfe_if.sv
sv/id3tfe_front.sv
sv/id3tfe_queue.sv
sv/id3tfe_back.sv
sv/id3v2_text_frame_extractor.sv
test/tb_id3v2_text_frame_extractor.sv
